// File: sv/sha1md_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SHA-1 message digest block.
// No dependencies; every other file refers to it by scoped names.
package sha1md_pkg;

  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned DIGEST_WORDS = 5;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] ROUND_B0   = 7'd20;
  localparam logic [6:0] ROUND_B1   = 7'd40;
  localparam logic [6:0] ROUND_B2   = 7'd60;

  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] PAD_LIMIT     = 6'd56;
  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [2:0] LAST_WORD_NUM = 3'd4;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [0:4][31:0] H_INIT = {
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_item_t;

  // One 512-bit block; word 0 is the first in message order.
  typedef struct packed {
    logic [15:0][31:0] words;
    logic              last;
  } blk_t;

endpackage

// File: sv/sha1md_front.sv
`timescale 1ns / 1ps
// Front end: packs message bytes into blocks, appends padding and length.
// Depends on sha1md_pkg.
module sha1md_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sha1md_pkg::in_item_t item,
  output logic               q_push,
  output sha1md_pkg::blk_t   q_data,
  input  logic               q_full
);

  typedef enum logic [2:0] {
    F_TAKE = 3'b001,
    F_PAD  = 3'b010,
    F_LEN  = 3'b100
  } front_state_t;

  front_state_t      state, state_next;
  logic [15:0][31:0] blk_words, blk_words_next;
  logic [5:0]        cnt, cnt_next;
  logic [60:0]       msg_count, msg_count_next;
  logic [15:0][31:0] merged_byte, merged_pad;
  logic [63:0]       bit_len;
  logic              accept;

  function automatic logic [15:0][31:0] put_byte(input logic [15:0][31:0] w,
                                                 input logic [5:0] pos,
                                                 input logic [7:0] b);
    logic [15:0][31:0] r;
    logic [1:0]        lane;
    r    = w;
    lane = 2'd3 - pos[1:0];
    r[pos[5:2]][{lane, 3'b000} +: 8] = r[pos[5:2]][{lane, 3'b000} +: 8] | b;
    return r;
  endfunction

  assign merged_byte = put_byte(blk_words, cnt, item.data_byte);
  assign merged_pad  = put_byte(blk_words, cnt, sha1md_pkg::PAD_BYTE);
  assign bit_len     = {msg_count, 3'b000};
  assign full        = (state != F_TAKE) || q_full;
  assign accept      = push && !full;

  always_comb begin
    state_next     = state;
    blk_words_next = blk_words;
    cnt_next       = cnt;
    msg_count_next = msg_count;
    q_push         = 1'b0;
    q_data         = '{words: merged_byte, last: 1'b0};
    unique case (state)
      F_TAKE: begin
        if (accept) begin
          if (item.has_byte) begin
            msg_count_next = msg_count + 61'd1;
            if (cnt == sha1md_pkg::LAST_BYTE_POS) begin
              // block complete: hand it on and start fresh
              q_push         = 1'b1;
              blk_words_next = '0;
              cnt_next       = '0;
            end else begin
              blk_words_next = merged_byte;
              cnt_next       = cnt + 6'd1;
            end
          end
          if (item.end_of_message) begin
            state_next = F_PAD;
          end
        end
      end
      F_PAD: begin
        q_data = '{words: merged_pad, last: 1'b0};
        if (cnt >= sha1md_pkg::PAD_LIMIT) begin
          // no room for the length: flush this block first
          if (!q_full) begin
            q_push         = 1'b1;
            blk_words_next = '0;
            cnt_next       = '0;
            state_next     = F_LEN;
          end
        end else begin
          blk_words_next = merged_pad;
          state_next     = F_LEN;
        end
      end
      F_LEN: begin
        q_data.words     = blk_words;
        q_data.words[14] = bit_len[63:32];
        q_data.words[15] = bit_len[31:0];
        q_data.last      = 1'b1;
        if (!q_full) begin
          q_push         = 1'b1;
          blk_words_next = '0;
          cnt_next       = '0;
          msg_count_next = '0;
          state_next     = F_TAKE;
        end
      end
      default: state_next = F_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_TAKE;
      blk_words <= '0;
      cnt       <= '0;
      msg_count <= '0;
    end else begin
      state     <= state_next;
      blk_words <= blk_words_next;
      cnt       <= cnt_next;
      msg_count <= msg_count_next;
    end
  end

endmodule

// File: sv/sha1md_blkq.sv
`timescale 1ns / 1ps
// Short block queue between the packing front end and the compression engine.
// Depends on sha1md_pkg.
module sha1md_blkq #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sha1md_pkg::blk_t wr_data,
  output logic             q_full,
  input  logic             rd,
  output sha1md_pkg::blk_t head,
  output logic             q_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sha1md_pkg::blk_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign q_full  = (count == FULL_CNT);
  assign q_empty = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/sha1md_back.sv
`timescale 1ns / 1ps
// Compression engine, one round per cycle, plus the digest output register.
// Depends on sha1md_pkg.
module sha1md_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  sha1md_pkg::blk_t      head,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output sha1md_pkg::out_item_t result
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_ROUND = 3'b010,
    B_FIN   = 3'b100
  } back_state_t;

  back_state_t       state;
  logic [0:4][31:0]  h;
  logic [31:0]       a, b, c, d, e;
  logic [15:0][31:0] w;
  logic [6:0]        rnd;
  logic              last_blk;
  logic [31:0]       outbuf [5];
  logic              out_valid;
  logic [2:0]        rd;
  logic [31:0]       f, k, t, w_new;
  logic [0:4][31:0]  sum;

  always_comb begin
    if (rnd < sha1md_pkg::ROUND_B0) begin
      f = (b & c) | (~b & d);
      k = sha1md_pkg::K0;
    end else if (rnd < sha1md_pkg::ROUND_B1) begin
      f = b ^ c ^ d;
      k = sha1md_pkg::K1;
    end else if (rnd < sha1md_pkg::ROUND_B2) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1md_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1md_pkg::K3;
    end
  end

  assign t     = {a[26:0], a[31:27]} + f + e + k + w[0];
  assign w_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                  w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};
  assign sum   = {h[0] + a, h[1] + b, h[2] + c, h[3] + d, h[4] + e};
  assign q_pop = (state == B_IDLE) && !q_empty;

  assign empty              = !out_valid;
  assign result.digest_word = outbuf[rd];
  assign result.word_number = rd;
  assign result.last_word   = (rd == sha1md_pkg::LAST_WORD_NUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      h         <= sha1md_pkg::H_INIT;
      rnd       <= '0;
      last_blk  <= 1'b0;
      out_valid <= 1'b0;
      rd        <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            w        <= head.words;
            last_blk <= head.last;
            {a, b, c, d, e} <= {h[0], h[1], h[2], h[3], h[4]};
            rnd      <= '0;
            state    <= B_ROUND;
          end
        end
        B_ROUND: begin
          a   <= t;
          b   <= a;
          c   <= {b[1:0], b[31:2]};
          d   <= c;
          e   <= d;
          w   <= {w_new, w[15:1]};
          rnd <= rnd + 7'd1;
          if (rnd == sha1md_pkg::LAST_ROUND) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          if (!last_blk) begin
            h     <= sum;
            state <= B_IDLE;
          end else if (!out_valid) begin
            // hand the digest to the output register, restart the chain
            for (int i = 0; i < 5; i++) begin
              outbuf[i] <= sum[i];
            end
            out_valid <= 1'b1;
            rd        <= '0;
            h         <= sha1md_pkg::H_INIT;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase

      if (pop && out_valid) begin
        if (rd == sha1md_pkg::LAST_WORD_NUM) begin
          out_valid <= 1'b0;
          rd        <= '0;
        end else begin
          rd <= rd + 3'd1;
        end
      end
    end
  end

endmodule

// File: sv/sha1_message_digest_top.sv
`timescale 1ns / 1ps
// Top level of the SHA-1 message digest block: front end, block queue, engine.
// Depends on sha1md_pkg, sha1md_front, sha1md_blkq and sha1md_back.
//
//   channel   handshake        payload                     transaction
//   item      push / full      data_byte, has_byte, eom    one byte step or end mark
//   result    empty / pop      digest_word, word_number,   one digest word, H0 first
//                              last_word
//
// The front end takes a byte step while not full; an end mark leads it
// through the padding state and the length state. Each 64-byte block then
// runs 80 rounds in the engine (one per cycle, plus load and final add),
// so on long messages the round loop sets the throughput.
// Reset (rst, synchronous) restores the initial hash and empties all queues.
// full rises while the front end pads or while the block queue is full;
// the engine stalls on a finished digest until the previous one is popped.
module sha1_message_digest_top #(
  parameter int unsigned BLOCK_QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  sha1md_pkg::in_item_t  item,
  output logic                  empty,
  input  logic                  pop,
  output sha1md_pkg::out_item_t result
);

  sha1md_pkg::blk_t q_wr_data, q_head;
  logic             q_wr, q_full, q_rd, q_empty;

  // Pack bytes and build the padded final block(s).
  sha1md_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_wr),
    .q_data (q_wr_data),
    .q_full (q_full)
  );

  // Hold finished blocks so packing can run ahead of compression.
  sha1md_blkq #(
    .DEPTH (BLOCK_QUEUE_DEPTH)
  ) u_blkq (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd      (q_rd),
    .head    (q_head),
    .q_empty (q_empty)
  );

  // Compress blocks and drain the digest one word per pop.
  sha1md_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (q_head),
    .q_pop   (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
